FILE: hdl/mspu_pkg.sv
`timescale 1ns / 1ps

package mspu_pkg;

  // command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_PACK   = 2'd2;
  localparam logic [1:0] CMD_UNPACK = 2'd3;

  // largest field length in bits
  localparam logic [5:0] MAX_LEN = 6'd32;

  // input item
  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  start_bit;
    logic [5:0]  bit_length;
    logic [31:0] field_value;
    logic [63:0] frame_in;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [31:0] value_out;
    logic [63:0] frame_out;
    logic        range_error;
  } out_item_t;

endpackage

FILE: hdl/motorola_signal_pack_unpack.sv
// an accepted transfer enters the input register, then the result register on out_data
// throughput: one command per cycle unless out_ready stalls; the frame register and result
//   register are updated in the same cycle, so back-to-back commands chain
// reset (rst_n low, synchronous): frame cleared to zero, both stages emptied
`timescale 1ns / 1ps

module motorola_signal_pack_unpack #(
  parameter int FRAME_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mspu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mspu_pkg::out_item_t out_data
);

  // bytes at or beyond FRAME_BYTES always read zero
  function automatic logic [63:0] mk_mask();
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (k < FRAME_BYTES) begin
        m[8*k +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  localparam logic [63:0] FRAME_MASK = mk_mask();

  mspu_pkg::in_item_t  in_r;
  logic                in_valid_r;
  logic                in_valid_nxt;
  mspu_pkg::out_item_t out_r;
  mspu_pkg::out_item_t out_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [63:0]         frame_r;
  logic [63:0]         frame_nxt;
  logic                advance;
  logic                in_xfer;

  // handshake
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  // signal datapath
  mspu_field #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_field (
    .item      (in_r),
    .frame_cur (frame_r),
    .frame_mask(FRAME_MASK),
    .result    (out_nxt),
    .frame_new (frame_nxt)
  );

  // stage valids
  always_comb begin
    in_valid_nxt  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      frame_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        frame_r <= frame_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a shown result always carries the current frame
  a_frame_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.frame_out == frame_r))
    else $error("result frame differs from frame register");

  // bytes outside the frame stay clear
  a_frame_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> ((frame_r & ~FRAME_MASK) == 64'd0))
    else $error("frame byte beyond frame length set");

  // a rejected field never yields a value
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.range_error) |-> (out_r.value_out == 32'd0))
    else $error("value present with range error");

  // input stage only stalls when it holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without cause");

  // a completed command appears at the output next cycle
  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result lost after advance");

endmodule

FILE: hdl/mspu_field.sv
`timescale 1ns / 1ps

module mspu_field #(
  parameter int FRAME_BYTES = 8
) (
  input  mspu_pkg::in_item_t  item,
  input  logic [63:0]         frame_cur,
  input  logic [63:0]         frame_mask,
  output mspu_pkg::out_item_t result,
  output logic [63:0]         frame_new
);

  localparam logic [3:0] BYTES_LIM = 4'(FRAME_BYTES);

  // reverse byte order: byte 0 moves to the top
  function automatic logic [63:0] bswap(input logic [63:0] w);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r[8*(7-k) +: 8] = w[8*k +: 8];
    end
    return r;
  endfunction

  logic [5:0]  lm1;
  logic        len_ok;
  logic [3:0]  diff;
  logic [2:0]  shamt;
  logic [2:0]  span;
  logic [2:0]  first;
  logic [2:0]  pad;
  logic        span_ok;
  logic        err;
  logic [63:0] big;
  logic [63:0] gath;
  logic [39:0] acc;
  logic [39:0] acc_sh;
  logic [31:0] vmask;
  logic [31:0] unpacked;
  logic [39:0] pv;
  logic [63:0] pw;
  logic [63:0] pw_pos;
  logic [63:0] packed_frame;

  // field geometry
  always_comb begin
    lm1     = item.bit_length - 6'd1;
    len_ok  = (item.bit_length != 6'd0) && (item.bit_length <= mspu_pkg::MAX_LEN);
    diff    = {1'b0, item.start_bit[2:0]} - {1'b0, lm1[2:0]};
    shamt   = diff[2:0];
    span    = {1'b0, lm1[4:3]} + 3'd1 + {2'b0, diff[3]};
    first   = item.start_bit[5:3];
    pad     = 3'd5 - span;
    span_ok = ({1'b0, first} + {1'b0, span}) <= BYTES_LIM;
    err     = !len_ok || !span_ok;
  end

  // gather span bytes most significant first, then align and mask
  always_comb begin
    big      = bswap(frame_cur);
    gath     = big << {first, 3'b000};
    acc      = gath[63:24] >> {pad, 3'b000};
    acc_sh   = acc >> shamt;
    vmask    = 32'hFFFF_FFFF >> (mspu_pkg::MAX_LEN - item.bit_length);
    unpacked = acc_sh[31:0] & vmask;
  end

  // place shifted value over the span, bits past the span fall off
  always_comb begin
    pv           = {8'b0, item.field_value} << shamt;
    pw           = {pv, 24'b0} << {pad, 3'b000};
    pw_pos       = pw >> {first, 3'b000};
    packed_frame = bswap(big | pw_pos) & frame_mask;
  end

  // command decode
  always_comb begin
    result.value_out   = '0;
    result.range_error = 1'b0;
    frame_new          = frame_cur;
    unique case (item.command)
      mspu_pkg::CMD_LOAD: begin
        frame_new = item.frame_in & frame_mask;
      end
      mspu_pkg::CMD_CLEAR: begin
        frame_new = '0;
      end
      mspu_pkg::CMD_PACK: begin
        result.range_error = err;
        if (!err) begin
          frame_new = packed_frame;
        end
      end
      mspu_pkg::CMD_UNPACK: begin
        result.range_error = err;
        if (!err) begin
          result.value_out = unpacked;
        end
      end
      default: begin
        frame_new = frame_cur;
      end
    endcase
    result.frame_out = frame_new;
  end

endmodule
